// ===== rtl/core/clce_pkg.sv =====
// shared constants, codes and types for the circular list cursor engine
`timescale 1ns / 1ps

package clce_pkg;

	// default sizes handed to the top level
	localparam int NODES_DEF        = 256;
	localparam int PAYLOAD_BITS_DEF = 32;

	// command codes
	localparam logic [1:0] CMD_INSERT  = 2'd0;
	localparam logic [1:0] CMD_REMOVE  = 2'd1;
	localparam logic [1:0] CMD_ADVANCE = 2'd2;

	// status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// write enables from the sequencer to the node store
	typedef struct packed {
		logic link_en;
		logic node_en;
		logic free_en;
	} clce_we_t;

endpackage

// ===== rtl/core/clce_store.sv =====
// node store: link memory, id/payload memory and free-node stack memory
`timescale 1ns / 1ps

module clce_store #(
	parameter int NODES        = 256,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                                         clk,
	input  clce_pkg::clce_we_t                           we,
	input  logic [((NODES > 1) ? $clog2(NODES) : 1)-1:0] link_waddr,
	input  logic [((NODES > 1) ? $clog2(NODES) : 1)-1:0] link_wdata,
	input  logic [((NODES > 1) ? $clog2(NODES) : 1)-1:0] link_raddr,
	output logic [((NODES > 1) ? $clog2(NODES) : 1)-1:0] link_rdata,
	input  logic [((NODES > 1) ? $clog2(NODES) : 1)-1:0] node_waddr,
	input  logic [32+PAYLOAD_BITS-1:0]                   node_wdata,
	input  logic [((NODES > 1) ? $clog2(NODES) : 1)-1:0] node_raddr,
	output logic [32+PAYLOAD_BITS-1:0]                   node_rdata,
	input  logic [((NODES > 1) ? $clog2(NODES) : 1)-1:0] free_waddr,
	input  logic [((NODES > 1) ? $clog2(NODES) : 1)-1:0] free_wdata,
	input  logic [((NODES > 1) ? $clog2(NODES) : 1)-1:0] free_raddr,
	output logic [((NODES > 1) ? $clog2(NODES) : 1)-1:0] free_rdata
);
	import clce_pkg::*;

	localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int DW = 32 + PAYLOAD_BITS;

	logic [IW-1:0] link_mem [NODES];
	logic [DW-1:0] node_mem [NODES];
	logic [IW-1:0] free_mem [NODES];

	// next-node links
	always_ff @(posedge clk) begin
		if (we.link_en) begin
			link_mem[link_waddr] <= link_wdata;
		end
		link_rdata <= link_mem[link_raddr];
	end

	// id and payload of each node
	always_ff @(posedge clk) begin
		if (we.node_en) begin
			node_mem[node_waddr] <= node_wdata;
		end
		node_rdata <= node_mem[node_raddr];
	end

	// stack of released node indices
	always_ff @(posedge clk) begin
		if (we.free_en) begin
			free_mem[free_waddr] <= free_wdata;
		end
		free_rdata <= free_mem[free_raddr];
	end

endmodule

// ===== rtl/core/circular_list_cursor_engine_top.sv =====
// top level: command sequencer, list registers and result register
`timescale 1ns / 1ps

// Circular singly linked list with a cursor, kept in three single-port-write
// memories (links, id/payload, free stack) with registered reads.
// One command is in work at a time; each gives exactly one result, held in an
// output register so that the next command can be taken while it waits.
// A command that changes nothing (empty remove, full insert, advance by zero
// or on an empty list, unused code) goes straight to S_FIN. An insert into an
// empty list or a remove of the last node passes S_INS_A or S_REM_A; other
// inserts and removes pass S_INS_B or S_REM_B too (an insert writes links
// twice through the one write port, a remove reads the dropped node's link).
// An advance walks one link per cycle through the link read port in S_ADV,
// then reads the node in S_ADV_RD. No clearing pass is needed after reset.
module circular_list_cursor_engine_top #(
	parameter int NODES        = clce_pkg::NODES_DEF,
	parameter int PAYLOAD_BITS = clce_pkg::PAYLOAD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] elem_id,
	input  logic [31:0]        elem_payload,
	input  logic [15:0]        step_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [8:0]         count,
	output logic               cursor_valid,
	output logic signed [31:0] cursor_id,
	output logic [31:0]        cursor_payload
);
	import clce_pkg::*;

	localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int CW = $clog2(NODES + 1);
	localparam int PW = PAYLOAD_BITS;
	localparam int DW = 32 + PW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_A,
		S_INS_B,
		S_REM_A,
		S_REM_B,
		S_ADV,
		S_ADV_RD,
		S_FIN
	} state_t;

	state_t        state_q;
	logic [IW-1:0] cursor_q;
	logic          has_q;
	logic [CW-1:0] size_q;
	logic [CW-1:0] fd_q;
	logic [CW-1:0] fresh_q;
	logic [IW-1:0] slot_q;
	logic [15:0]   steps_q;
	logic [31:0]   id_q;
	logic [PW-1:0] pay_q;
	logic [1:0]    status_q;
	logic [31:0]   cur_id_q;
	logic [PW-1:0] cur_pay_q;
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [8:0]    out_count_q;
	logic          out_cv_q;
	logic [31:0]   out_id_q;
	logic [31:0]   out_pay_q;

	clce_we_t      we;
	logic [IW-1:0] link_waddr, link_wdata, link_raddr, link_rd;
	logic [IW-1:0] node_waddr;
	logic [DW-1:0] node_wdata, node_rd;
	logic [IW-1:0] free_waddr, free_wdata, free_rd;
	logic [IW-1:0] slot_new;
	logic [CW-1:0] fd_dec;
	logic [63:0]   pay_in_ext;
	logic [63:0]   cur_pay_ext;
	logic          full;

	// payload width adaption
	assign pay_in_ext  = 64'(elem_payload);
	assign cur_pay_ext = 64'(cur_pay_q);

	// node allocation: free stack first, then the next never-used index
	assign fd_dec   = fd_q - CW'(1);
	assign slot_new = (fd_q != '0) ? free_rd : fresh_q[IW-1:0];
	assign full     = (size_q == CW'(NODES));

	// memory read addresses
	assign link_raddr = (state_q == S_IDLE) ? cursor_q : link_rd;

	// memory write control
	always_comb begin
		we         = '0;
		link_waddr = cursor_q;
		link_wdata = slot_q;
		node_waddr = slot_new;
		node_wdata = {id_q, pay_q};
		free_waddr = fd_q[IW-1:0];
		free_wdata = link_rd;
		case (state_q)
			S_INS_A: begin
				we.node_en = 1'b1;
				we.link_en = 1'b1;
				link_waddr = slot_new;
				link_wdata = has_q ? link_rd : slot_new;
			end
			S_INS_B: begin
				we.link_en = 1'b1;
			end
			S_REM_A: begin
				we.free_en = (fd_q != CW'(NODES));
			end
			S_REM_B: begin
				we.link_en = 1'b1;
				link_wdata = link_rd;
			end
			default: begin
				we = '0;
			end
		endcase
	end

	clce_store #(
		.NODES        (NODES),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_store (
		.clk        (clk),
		.we         (we),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.link_raddr (link_raddr),
		.link_rdata (link_rd),
		.node_waddr (node_waddr),
		.node_wdata (node_wdata),
		.node_raddr (link_rd),
		.node_rdata (node_rd),
		.free_waddr (free_waddr),
		.free_wdata (free_wdata),
		.free_raddr (fd_dec[IW-1:0]),
		.free_rdata (free_rd)
	);

	// sequencer, list registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cursor_q     <= '0;
			has_q        <= 1'b0;
			size_q       <= '0;
			fd_q         <= '0;
			fresh_q      <= '0;
			slot_q       <= '0;
			steps_q      <= '0;
			id_q         <= '0;
			pay_q        <= '0;
			status_q     <= ST_DONE;
			cur_id_q     <= '0;
			cur_pay_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_DONE;
			out_count_q  <= '0;
			out_cv_q     <= 1'b0;
			out_id_q     <= '0;
			out_pay_q    <= '0;
		end else begin
			// result taken while no new one is being loaded
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						id_q    <= elem_id;
						pay_q   <= pay_in_ext[PW-1:0];
						steps_q <= step_count;
						case (cmd)
							CMD_INSERT: begin
								if (full) begin
									status_q <= ST_FULL;
									state_q  <= S_FIN;
								end else begin
									status_q <= ST_DONE;
									state_q  <= S_INS_A;
								end
							end
							CMD_REMOVE: begin
								if (!has_q) begin
									status_q <= ST_EMPTY;
									state_q  <= S_FIN;
								end else begin
									status_q <= ST_DONE;
									state_q  <= S_REM_A;
								end
							end
							CMD_ADVANCE: begin
								status_q <= ST_DONE;
								if (has_q && step_count != '0) begin
									state_q <= S_ADV;
								end else begin
									state_q <= S_FIN;
								end
							end
							default: begin
								status_q <= ST_DONE;
								state_q  <= S_FIN;
							end
						endcase
					end
				end
				S_INS_A: begin
					slot_q <= slot_new;
					size_q <= size_q + CW'(1);
					if (fd_q != '0) begin
						fd_q <= fd_dec;
					end else begin
						fresh_q <= fresh_q + CW'(1);
					end
					if (!has_q) begin
						cursor_q  <= slot_new;
						has_q     <= 1'b1;
						cur_id_q  <= id_q;
						cur_pay_q <= pay_q;
						state_q   <= S_FIN;
					end else begin
						state_q <= S_INS_B;
					end
				end
				S_INS_B: begin
					state_q <= S_FIN;
				end
				S_REM_A: begin
					// link_rd holds the node after the cursor
					if (fd_q != CW'(NODES)) begin
						fd_q <= fd_q + CW'(1);
					end
					if (size_q != '0) begin
						size_q <= size_q - CW'(1);
					end
					if (link_rd == cursor_q) begin
						has_q    <= 1'b0;
						cursor_q <= '0;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_REM_B;
					end
				end
				S_REM_B: begin
					state_q <= S_FIN;
				end
				S_ADV: begin
					// one link per cycle
					cursor_q <= link_rd;
					steps_q  <= steps_q - 16'd1;
					if (steps_q == 16'd1) begin
						state_q <= S_ADV_RD;
					end
				end
				S_ADV_RD: begin
					cur_id_q  <= node_rd[DW-1:PW];
					cur_pay_q <= node_rd[PW-1:0];
					state_q   <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_count_q  <= 9'(size_q);
						out_cv_q     <= has_q;
						out_id_q     <= has_q ? cur_id_q : 32'd0;
						out_pay_q    <= has_q ? cur_pay_ext[31:0] : 32'd0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// port drive
	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign count          = out_count_q;
	assign cursor_valid   = out_cv_q;
	assign cursor_id      = out_id_q;
	assign cursor_payload = out_pay_q;

endmodule

// ===== rtl/core/clce_checker.sv =====
// port-level checks for the circular list cursor engine, bound to the top level
`timescale 1ns / 1ps

module clce_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic [8:0]         count,
	input logic               cursor_valid,
	input logic signed [31:0] cursor_id,
	input logic [31:0]        cursor_payload
);
	import clce_pkg::*;

	// an empty list reports no cursor data
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cursor_valid |-> count == 9'd0 && cursor_id == 32'sd0
			&& cursor_payload == 32'd0)
		else $error("empty list result carries cursor data");

	// remove refused only when the list is empty
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> !cursor_valid)
		else $error("empty status with a valid cursor");

	// a full store always has a cursor
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> cursor_valid)
		else $error("full status with no cursor");

	// the engine is busy in the cycle after it accepts a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("next transaction taken straight after acceptance");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count)
			&& $stable(cursor_id) && $stable(cursor_payload))
		else $error("stalled result changed");

endmodule

bind circular_list_cursor_engine_top clce_checker u_clce_checker (.*);
